// ----- rtl/core/gmms_pkg.sv -----
// gmms_pkg: shared widths, codes and item types of the median smoother
// no dependencies; used by the interfaces, the cell row and the top level
`default_nettype none

package gmms_pkg;

  // field widths
  localparam int DATA_W     = 32;
  localparam int SCAN_W     = 10;
  localparam int REJ_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int WINDOW_DEF = 5;

  localparam logic [REJ_W-1:0]  REJ_MAX   = '1;
  localparam logic [DATA_W-1:0] LIMIT_RST = '1;

  // result grade
  typedef enum logic [1:0] {
    Q_OK         = 2'd0,
    Q_LOW_SCAN   = 2'd1,
    Q_HIGH_SIGMA = 2'd2,
    Q_JUMP       = 2'd3
  } quality_t;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_SCAN  = 2'd0,
    REG_MAX_SIGMA = 2'd1,
    REG_MAX_JUMP  = 2'd2
  } cfg_reg_t;

  // input item
  typedef struct packed {
    logic [DATA_W-1:0] pixel_dist;
    logic [DATA_W-1:0] world_dist;
    logic              world_valid;
    logic [DATA_W-1:0] sigma;
    logic              sigma_known;
    logic [SCAN_W-1:0] scan_count;
  } item_t;

  // graded item between the check stage and the output stage
  typedef struct packed {
    quality_t          quality;
    logic [DATA_W-1:0] pixel_raw;
    logic [DATA_W-1:0] world_raw;
    logic              world_valid;
    logic [DATA_W-1:0] jump;
    logic [REJ_W-1:0]  reject_run;
  } graded_t;

  // result item
  typedef struct packed {
    quality_t          quality;
    logic [DATA_W-1:0] pixel_out;
    logic [DATA_W-1:0] world_out;
    logic              world_out_valid;
    logic [DATA_W-1:0] jump_amount;
    logic [REJ_W-1:0]  reject_run;
  } result_t;

  // push request into a window
  typedef struct packed {
    logic              push;
    logic [DATA_W-1:0] value;
  } push_t;

  // window status
  typedef struct packed {
    logic              empty;
    logic [DATA_W-1:0] median;
  } win_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/gmms_ifs.sv -----
// gmms channel interfaces: input items, result items and register writes
// depends on gmms_pkg for field widths
`default_nettype none

interface gmms_in_if;
  logic                        valid;
  logic                        ready;
  logic [gmms_pkg::DATA_W-1:0] pixel_dist;
  logic [gmms_pkg::DATA_W-1:0] world_dist;
  logic                        world_valid;
  logic [gmms_pkg::DATA_W-1:0] sigma;
  logic                        sigma_known;
  logic [gmms_pkg::SCAN_W-1:0] scan_count;

  modport source (output valid, pixel_dist, world_dist, world_valid, sigma, sigma_known,
                  scan_count, input ready);
  modport sink (input valid, pixel_dist, world_dist, world_valid, sigma, sigma_known,
                scan_count, output ready);
endinterface

interface gmms_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  quality;
  logic [gmms_pkg::DATA_W-1:0] pixel_out;
  logic [gmms_pkg::DATA_W-1:0] world_out;
  logic                        world_out_valid;
  logic [gmms_pkg::DATA_W-1:0] jump_amount;
  logic [gmms_pkg::REJ_W-1:0]  reject_run;

  modport source (output valid, quality, pixel_out, world_out, world_out_valid, jump_amount,
                  reject_run, input ready);
  modport sink (input valid, quality, pixel_out, world_out, world_out_valid, jump_amount,
                reject_run, output ready);
endinterface

interface gmms_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gmms_pkg::CFG_IDX_W-1:0] index;
  logic [gmms_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gmms_cell.sv -----
// gmms_cell: one slot of a sorted sliding window, holding a value and its age
// depends on gmms_pkg; chained by gmms_window, exchanging data with both neighbours
`default_nettype none

module gmms_cell #(
  parameter int AGE_W  = 3,
  parameter int OLDEST = 4
) (
  input  wire logic                        clk,
  input  wire logic                        push,
  input  wire logic                        full,
  input  wire logic [gmms_pkg::DATA_W-1:0] ins_val,
  input  wire logic                        rem_valid,
  // from the left neighbour
  input  wire logic                        del_in,
  input  wire logic [gmms_pkg::DATA_W-1:0] prv_rem_val,
  input  wire logic [AGE_W-1:0]            prv_rem_age,
  input  wire logic                        prv_ge,
  // from the right neighbour
  input  wire logic [gmms_pkg::DATA_W-1:0] nbr_val,
  input  wire logic [AGE_W-1:0]            nbr_age,
  // to the neighbours
  output logic                             del_out,
  output logic [gmms_pkg::DATA_W-1:0]      rem_val,
  output logic [AGE_W-1:0]                 rem_age,
  output logic                             ge,
  output logic [gmms_pkg::DATA_W-1:0]      val,
  output logic [AGE_W-1:0]                 age
);

  logic [gmms_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [AGE_W-1:0]            age_r, age_nxt;

  // the oldest entry leaves when the window is full; cells to its right move left
  assign del_out = del_in | (full && (age_r == AGE_W'(OLDEST)));
  assign rem_val = del_out ? nbr_val : val_r;
  assign rem_age = del_out ? nbr_age : age_r;

  // at or past the insertion point of the new value
  assign ge = !(rem_valid && (rem_val <= ins_val));

  // next contents: keep or take the right value, the new value, or the left value
  always_comb begin
    if (!ge) begin
      val_nxt = rem_val;
      age_nxt = rem_age + AGE_W'(1);
    end else if (prv_ge) begin
      val_nxt = prv_rem_val;
      age_nxt = prv_rem_age + AGE_W'(1);
    end else begin
      val_nxt = ins_val;
      age_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign val = val_r;
  assign age = age_r;

endmodule

`default_nettype wire

// ----- rtl/core/gmms_window.sv -----
// gmms_window: row of gmms_cell slots kept in ascending order, fill count and median tap
// depends on gmms_pkg and gmms_cell
`default_nettype none

module gmms_window #(
  parameter int WINDOW = gmms_pkg::WINDOW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gmms_pkg::push_t   req,
  output gmms_pkg::win_stat_t    stat
);

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              full;
  logic [FILL_W-1:0] rem_cnt;

  logic [WINDOW:0]                del_c;
  logic [WINDOW:0]                ge_c;
  logic [gmms_pkg::DATA_W-1:0]    rem_val_c [WINDOW+1];
  logic [FILL_W-1:0]              rem_age_c [WINDOW+1];
  logic [gmms_pkg::DATA_W-1:0]    val_c     [WINDOW+1];
  logic [FILL_W-1:0]              age_c     [WINDOW+1];
  logic [WINDOW-1:0]              rem_valid;
  logic [WINDOW-1:0]              lo_hot, hi_hot;
  logic [FILL_W-1:0]              lo_pos, hi_pos;
  logic [gmms_pkg::DATA_W-1:0]    lo_val, hi_val;
  logic [gmms_pkg::DATA_W:0]      mid_sum;

  assign full    = (fill_r == FILL_W'(WINDOW));
  assign rem_cnt = full ? FILL_W'(WINDOW - 1) : fill_r;

  // chain ends
  assign del_c[0]         = 1'b0;
  assign ge_c[0]          = 1'b0;
  assign rem_val_c[0]     = '0;
  assign rem_age_c[0]     = '0;
  assign val_c[WINDOW]    = '0;
  assign age_c[WINDOW]    = '0;

  // cell row
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    assign rem_valid[i] = (FILL_W'(i) < rem_cnt);
    assign lo_hot[i]    = (lo_pos[IDX_W-1:0] == IDX_W'(i));
    assign hi_hot[i]    = (hi_pos[IDX_W-1:0] == IDX_W'(i));

    gmms_cell #(
      .AGE_W  (FILL_W),
      .OLDEST (WINDOW - 1)
    ) u_cell (
      .clk         (clk),
      .push        (req.push),
      .full        (full),
      .ins_val     (req.value),
      .rem_valid   (rem_valid[i]),
      .del_in      (del_c[i]),
      .prv_rem_val (rem_val_c[i]),
      .prv_rem_age (rem_age_c[i]),
      .prv_ge      (ge_c[i]),
      .nbr_val     (val_c[i+1]),
      .nbr_age     (age_c[i+1]),
      .del_out     (del_c[i+1]),
      .rem_val     (rem_val_c[i+1]),
      .rem_age     (rem_age_c[i+1]),
      .ge          (ge_c[i+1]),
      .val         (val_c[i]),
      .age         (age_c[i])
    );
  end

  // fill count
  assign fill_nxt = full ? fill_r : fill_r + FILL_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (req.push) begin
      fill_r <= fill_nxt;
    end
  end

  // middle taps: (n-1)/2 and n/2, equal for an odd count
  assign lo_pos = (fill_r - FILL_W'(1)) >> 1;
  assign hi_pos = fill_r >> 1;

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int k = 0; k < WINDOW; k++) begin
      if (lo_hot[k]) lo_val = lo_val | val_c[k];
      if (hi_hot[k]) hi_val = hi_val | val_c[k];
    end
  end

  // truncated mean of the two middle values
  assign mid_sum     = {1'b0, lo_val} + {1'b0, hi_val};
  assign stat.median = mid_sum[gmms_pkg::DATA_W:1];
  assign stat.empty  = (fill_r == '0);

endmodule

`default_nettype wire

// ----- rtl/core/gated_median_measurement_smoother.sv -----
// gated_median_measurement_smoother: grades each item, keeps running medians, counts rejects
// Every item passes three register stages (s1, s2, s3) before its result is valid.
// Throughput: one item per cycle while the output is not stalled; the cell row takes one insert per
// cycle, so state from one item is ready for the grading of the next.
// Reset (synchronous, rst_n low): stage valids, fill counts, reject count and registers to
// their defaults; window contents are left as they are. Depends on gmms_pkg, gmms_ifs, gmms_window.
`default_nettype none

module gated_median_measurement_smoother #(
  parameter int WINDOW = gmms_pkg::WINDOW_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gmms_in_if.sink     in_ch,
  gmms_out_if.source  out_ch,
  gmms_cfg_if.sink    cfg_ch
);

  // configuration registers
  logic [gmms_pkg::SCAN_W-1:0] min_scan_r;
  logic [gmms_pkg::DATA_W-1:0] max_sigma_r;
  logic [gmms_pkg::DATA_W-1:0] max_jump_r;

  // pipeline
  logic                 en;
  logic                 s1_v_r, s2_v_r, s3_v_r;
  gmms_pkg::item_t      s1_r, in_item;
  gmms_pkg::graded_t    s2_r, s2_nxt;
  gmms_pkg::result_t    s3_r, s3_nxt;
  logic [gmms_pkg::REJ_W-1:0] rej_r, rej_nxt;

  // grading
  logic                        low_scan, sigma_fail, jump_chk, jump_fail, ok;
  logic [gmms_pkg::DATA_W-1:0] diff;
  gmms_pkg::quality_t          qual;
  gmms_pkg::push_t             pix_req, wor_req;
  gmms_pkg::win_stat_t         pix_stat, wor_stat;

  // register writes, taken whenever out of reset
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_scan_r  <= '0;
      max_sigma_r <= gmms_pkg::LIMIT_RST;
      max_jump_r  <= gmms_pkg::LIMIT_RST;
    end else if (cfg_ch.valid) begin
      case (gmms_pkg::cfg_reg_t'(cfg_ch.index))
        gmms_pkg::REG_MIN_SCAN:  min_scan_r  <= cfg_ch.data[gmms_pkg::SCAN_W-1:0];
        gmms_pkg::REG_MAX_SIGMA: max_sigma_r <= cfg_ch.data;
        gmms_pkg::REG_MAX_JUMP:  max_jump_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves when the output register is free or being taken
  assign en          = !s3_v_r || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  assign in_item.pixel_dist  = in_ch.pixel_dist;
  assign in_item.world_dist  = in_ch.world_dist;
  assign in_item.world_valid = in_ch.world_valid;
  assign in_item.sigma       = in_ch.sigma;
  assign in_item.sigma_known = in_ch.sigma_known;
  assign in_item.scan_count  = in_ch.scan_count;

  // grading checks against the current world history
  assign low_scan   = (min_scan_r != '0) && (s1_r.scan_count < min_scan_r);
  assign sigma_fail = s1_r.sigma_known && (s1_r.sigma > max_sigma_r);
  assign jump_chk   = !wor_stat.empty && s1_r.world_valid;
  assign diff       = (s1_r.world_dist >= wor_stat.median) ?
                      (s1_r.world_dist - wor_stat.median) :
                      (wor_stat.median - s1_r.world_dist);
  assign jump_fail  = jump_chk && (diff > max_jump_r);

  always_comb begin
    if (low_scan) begin
      qual = gmms_pkg::Q_LOW_SCAN;
    end else if (sigma_fail) begin
      qual = gmms_pkg::Q_HIGH_SIGMA;
    end else if (jump_fail) begin
      qual = gmms_pkg::Q_JUMP;
    end else begin
      qual = gmms_pkg::Q_OK;
    end
  end

  assign ok = (qual == gmms_pkg::Q_OK);

  // reject run, saturating
  always_comb begin
    if (ok) begin
      rej_nxt = '0;
    end else if (rej_r == gmms_pkg::REJ_MAX) begin
      rej_nxt = rej_r;
    end else begin
      rej_nxt = rej_r + gmms_pkg::REJ_W'(1);
    end
  end

  // window pushes for accepted graded items
  assign pix_req.push  = en && s1_v_r && ok;
  assign pix_req.value = s1_r.pixel_dist;
  assign wor_req.push  = en && s1_v_r && ok && s1_r.world_valid;
  assign wor_req.value = s1_r.world_dist;

  gmms_window #(.WINDOW(WINDOW)) u_pix_win (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pix_req),
    .stat  (pix_stat)
  );

  gmms_window #(.WINDOW(WINDOW)) u_wor_win (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (wor_req),
    .stat  (wor_stat)
  );

  // graded item
  always_comb begin
    s2_nxt.quality     = qual;
    s2_nxt.pixel_raw   = s1_r.pixel_dist;
    s2_nxt.world_raw   = s1_r.world_dist;
    s2_nxt.world_valid = s1_r.world_valid;
    s2_nxt.jump        = (!low_scan && !sigma_fail && jump_chk) ? diff : '0;
    s2_nxt.reject_run  = rej_nxt;
  end

  // result item: windows now hold the state left by the item in stage two
  always_comb begin
    s3_nxt.quality         = s2_r.quality;
    s3_nxt.pixel_out       = (s2_r.quality == gmms_pkg::Q_OK) ? pix_stat.median
                                                                : s2_r.pixel_raw;
    s3_nxt.world_out       = ((s2_r.quality == gmms_pkg::Q_OK) && s2_r.world_valid) ?
                             wor_stat.median : s2_r.world_raw;
    s3_nxt.world_out_valid = s2_r.world_valid;
    s3_nxt.jump_amount     = s2_r.jump;
    s3_nxt.reject_run      = s2_r.reject_run;
  end

  // stage valids and reject count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      rej_r  <= '0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (s1_v_r) rej_r <= rej_nxt;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= in_item;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  // result port
  assign out_ch.valid           = s3_v_r;
  assign out_ch.quality         = s3_r.quality;
  assign out_ch.pixel_out       = s3_r.pixel_out;
  assign out_ch.world_out       = s3_r.world_out;
  assign out_ch.world_out_valid = s3_r.world_out_valid;
  assign out_ch.jump_amount     = s3_r.jump_amount;
  assign out_ch.reject_run      = s3_r.reject_run;

  // an ok item always leaves a cleared reject run
  a_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && (s2_r.quality == gmms_pkg::Q_OK)) |-> (s2_r.reject_run == '0))
    else $error("ok item with nonzero reject run");

  // an ok item in stage two has left at least one value in the pixel window
  a_ok_filled: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && (s2_r.quality == gmms_pkg::Q_OK)) |-> !pix_stat.empty)
    else $error("ok item left the pixel window empty");

  // items stopped before the jump check report no jump
  a_early_no_jump: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && ((s2_r.quality == gmms_pkg::Q_LOW_SCAN) ||
                (s2_r.quality == gmms_pkg::Q_HIGH_SIGMA))) |-> (s2_r.jump == '0))
    else $error("jump reported for an item failing an earlier check");

  // world window only grows alongside the pixel window
  a_push_pair: assert property (@(posedge clk) disable iff (!rst_n)
    wor_req.push |-> pix_req.push)
    else $error("world push without pixel push");

  // a stalled result keeps the whole pipeline still
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(s2_r.reject_run)))
    else $error("pipeline moved during a stall");

endmodule

`default_nettype wire
